@@ rtl/bsr_pkg.sv @@
package bsr_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 1024;

   localparam int IDX_W  = 32;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 11;
   localparam int OP_W   = 2;
   localparam int REQ_W  = 40;
   localparam int RSP_W  = 32;

   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_END  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

   typedef struct packed {
      logic              input_ended;
      logic [CNT_W-1:0]  buffered_count;
      logic [CNT_W-1:0]  unassembled_count;
      logic              read_valid;
      logic [BYTE_W-1:0] read_byte;
   } bsr_rsp_type;

endpackage

@@ rtl/bsr_rsp_reg.sv @@
module bsr_rsp_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  bsr_pkg::bsr_rsp_type       load_data,
   output logic                       load_ready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // read_byte, read_valid, unassembled_count, buffered_count, input_ended
   output logic [bsr_pkg::RSP_W-1:0]  rsp_tdata
);
   import bsr_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   bsr_rsp_type data_ff;

   assign load_ready = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

@@ rtl/byte_stream_reassembler.sv @@
// Channel   Ports   Fields
// request   req_    tuser: operation; tdata: stream_index, data_byte
// response  rsp_    tdata: read_byte, read_valid, unassembled_count,
//                          buffered_count, input_ended
//
// An end mark, a no-op, an empty read or a dropped push passes through EXEC and
// DONE; a read of a byte adds RDATA, a push that reaches the store adds PCHK,
// and a push that lands on the assembled point also adds SCAN, which moves the
// assembled point over each valid byte. After reset the valid memory is cleared.
// The result is held in an output register, so the next word is taken while
// a result waits; a result that cannot be loaded holds the block.
module byte_stream_reassembler #(
   parameter int unsigned CAPACITY = bsr_pkg::CAPACITY_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // stream_index, data_byte
   input  logic [bsr_pkg::REQ_W-1:0]  req_tdata,
   // operation
   input  logic [bsr_pkg::OP_W-1:0]   req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // read_byte, read_valid, unassembled_count, buffered_count, input_ended
   output logic [bsr_pkg::RSP_W-1:0]  rsp_tdata
);
   import bsr_pkg::*;

   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [SW:0]      CAP_S     = (SW+1)'(CAPACITY);
   localparam logic [SW-1:0]    LAST_SLOT = SW'(CAPACITY - 1);
   localparam logic [IDX_W-1:0] CAP_I     = IDX_W'(CAPACITY);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_PCHK  = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_RDATA = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic               valid_mem [CAPACITY];
   logic [BYTE_W-1:0]  byte_mem  [CAPACITY];

   logic [2:0]         state_ff, state_in;
   logic [SW-1:0]      clr_ff, clr_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [BYTE_W-1:0]  data_ff, data_in;
   logic [IDX_W-1:0]   asm_ff, asm_in;
   logic [SW-1:0]      asm_slot_ff, asm_slot_in;
   logic [IDX_W-1:0]   rd_ff, rd_in;
   logic [SW-1:0]      rd_slot_ff, rd_slot_in;
   logic [IDX_W-1:0]   end_idx_ff, end_idx_in;
   logic               end_known_ff, end_known_in;
   logic [CW-1:0]      pending_ff, pending_in;
   logic [SW-1:0]      push_slot_ff, push_slot_in;
   logic               push_head_ff, push_head_in;
   logic [BYTE_W-1:0]  rbyte_ff, rbyte_in;
   logic               rvalid_ff, rvalid_in;

   logic               vmem_we, vmem_wdata, vmem_re, vmem_rdata_ff;
   logic [SW-1:0]      vmem_waddr, vmem_raddr;
   logic               bmem_we, bmem_re;
   logic [SW-1:0]      bmem_waddr, bmem_raddr;
   logic [BYTE_W-1:0]  bmem_wdata, bmem_rdata_ff;

   logic [IDX_W-1:0]   buf_c, room_c, off_c, end_diff_c, pend_c;
   logic               in_win_c;
   logic [SW:0]        slot_sum_c;
   logic [SW-1:0]      push_slot_c, asm_slot_inc_c, rd_slot_inc_c;

   logic               out_load, out_ready;
   bsr_rsp_type        out_data;

   always_comb begin
      buf_c      = asm_ff - rd_ff;
      room_c     = (buf_c < CAP_I) ? (CAP_I - buf_c) : '0;
      off_c      = idx_ff - asm_ff;
      in_win_c   = off_c < room_c;
      slot_sum_c = {1'b0, asm_slot_ff} + {1'b0, off_c[SW-1:0]};
      push_slot_c = (slot_sum_c >= CAP_S) ? SW'(slot_sum_c - CAP_S) : slot_sum_c[SW-1:0];
      asm_slot_inc_c = (asm_slot_ff == LAST_SLOT) ? '0 : asm_slot_ff + SW'(1);
      rd_slot_inc_c  = (rd_slot_ff == LAST_SLOT) ? '0 : rd_slot_ff + SW'(1);
      end_diff_c = asm_ff - end_idx_ff;
      pend_c     = IDX_W'(pending_ff);
   end

   assign req_tready = (state_ff == ST_IDLE);

   assign out_data.read_byte         = rbyte_ff;
   assign out_data.read_valid        = rvalid_ff;
   assign out_data.unassembled_count = pend_c[CNT_W-1:0];
   assign out_data.buffered_count    = buf_c[CNT_W-1:0];
   assign out_data.input_ended       = end_known_ff && !end_diff_c[IDX_W-1];

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      data_in      = data_ff;
      asm_in       = asm_ff;
      asm_slot_in  = asm_slot_ff;
      rd_in        = rd_ff;
      rd_slot_in   = rd_slot_ff;
      end_idx_in   = end_idx_ff;
      end_known_in = end_known_ff;
      pending_in   = pending_ff;
      push_slot_in = push_slot_ff;
      push_head_in = push_head_ff;
      rbyte_in     = rbyte_ff;
      rvalid_in    = rvalid_ff;
      vmem_we      = 1'b0;
      vmem_waddr   = asm_slot_ff;
      vmem_wdata   = 1'b0;
      vmem_re      = 1'b0;
      vmem_raddr   = asm_slot_ff;
      bmem_we      = 1'b0;
      bmem_waddr   = push_slot_ff;
      bmem_wdata   = data_ff;
      bmem_re      = 1'b0;
      bmem_raddr   = rd_slot_ff;
      out_load     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            vmem_we    = 1'b1;
            vmem_waddr = clr_ff;
            vmem_wdata = 1'b0;
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + SW'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               idx_in    = req_tdata[IDX_W-1:0];
               data_in   = req_tdata[IDX_W +: BYTE_W];
               rbyte_in  = '0;
               rvalid_in = 1'b0;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (op_ff)
               OP_PUSH: begin
                  if (in_win_c) begin
                     vmem_re      = 1'b1;
                     vmem_raddr   = push_slot_c;
                     push_slot_in = push_slot_c;
                     push_head_in = (off_c == '0);
                     state_in     = ST_PCHK;
                  end
               end
               OP_END: begin
                  end_idx_in   = idx_ff;
                  end_known_in = 1'b1;
               end
               OP_READ: begin
                  if (asm_ff != rd_ff) begin
                     bmem_re    = 1'b1;
                     bmem_raddr = rd_slot_ff;
                     rd_in      = rd_ff + IDX_W'(1);
                     rd_slot_in = rd_slot_inc_c;
                     state_in   = ST_RDATA;
                  end
               end
               OP_NOP: begin
               end
            endcase
         end
         ST_PCHK: begin
            state_in = ST_DONE;
            if (!vmem_rdata_ff) begin
               bmem_we = 1'b1;
               if (push_head_ff) begin
                  asm_in      = asm_ff + IDX_W'(1);
                  asm_slot_in = asm_slot_inc_c;
                  vmem_re     = 1'b1;
                  vmem_raddr  = asm_slot_inc_c;
                  state_in    = ST_SCAN;
               end else begin
                  vmem_we    = 1'b1;
                  vmem_waddr = push_slot_ff;
                  vmem_wdata = 1'b1;
                  pending_in = pending_ff + CW'(1);
               end
            end
         end
         ST_SCAN: begin
            if (vmem_rdata_ff) begin
               vmem_we     = 1'b1;
               vmem_waddr  = asm_slot_ff;
               vmem_wdata  = 1'b0;
               if (pending_ff != '0) begin
                  pending_in = pending_ff - CW'(1);
               end
               asm_in      = asm_ff + IDX_W'(1);
               asm_slot_in = asm_slot_inc_c;
               vmem_re     = 1'b1;
               vmem_raddr  = asm_slot_inc_c;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RDATA: begin
            rbyte_in  = bmem_rdata_ff;
            rvalid_in = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         asm_ff       <= '0;
         asm_slot_ff  <= '0;
         rd_ff        <= '0;
         rd_slot_ff   <= '0;
         end_idx_ff   <= '0;
         end_known_ff <= 1'b0;
         pending_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         asm_ff       <= asm_in;
         asm_slot_ff  <= asm_slot_in;
         rd_ff        <= rd_in;
         rd_slot_ff   <= rd_slot_in;
         end_idx_ff   <= end_idx_in;
         end_known_ff <= end_known_in;
         pending_ff   <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      data_ff      <= data_in;
      push_slot_ff <= push_slot_in;
      push_head_ff <= push_head_in;
      rbyte_ff     <= rbyte_in;
      rvalid_ff    <= rvalid_in;
   end

   always_ff @(posedge clock) begin
      if (vmem_we) begin
         valid_mem[vmem_waddr] <= vmem_wdata;
      end
      if (vmem_re) begin
         vmem_rdata_ff <= valid_mem[vmem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (bmem_we) begin
         byte_mem[bmem_waddr] <= bmem_wdata;
      end
      if (bmem_re) begin
         bmem_rdata_ff <= byte_mem[bmem_raddr];
      end
   end

   bsr_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .load_data  (out_data),
      .load_ready (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assert property (@(posedge clock) disable iff (reset)
      pend_c <= CAP_I)
      else $error("Pending byte count exceeds the store size.");

   assert property (@(posedge clock) disable iff (reset)
      buf_c <= CAP_I)
      else $error("Assembled bytes overrun the unread window.");

   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, asm_slot_ff} < CAP_S) && ({1'b0, rd_slot_ff} < CAP_S))
      else $error("Slot pointer left the store.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rvalid_ff) |-> (op_ff == OP_READ))
      else $error("Read byte flagged for an operation that is not a read.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && vmem_rdata_ff) |=> (asm_ff == $past(asm_ff) + IDX_W'(1)))
      else $error("Assembled point failed to advance over a valid byte.");

endmodule
